[design/uvf_pkg.sv]
// Package: shared constants, codes and types for the unique value FIFO.
`default_nettype none
package uvf_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEF     = 16;
    localparam int OCC_W         = 5;
    localparam int GRP_W         = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RED  = 4'b0100,
        S_EXEC = 4'b1000
    } t_state;

    typedef struct packed {
        logic live;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

[design/uvf_cell.sv]
// Queue cell: one stored entry, its compare against the probe, shift toward the head.
`default_nettype none
module uvf_cell
    import uvf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic signed [DATA_W-1:0] i_next_data,
    output logic signed [DATA_W-1:0]      o_data,
    output logic                          o_hit
);

    logic signed [DATA_W-1:0] r_data;
    logic                     r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_value;
        end else if (i_ctl.shift) begin
            r_data <= i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= i_ctl.live && (r_data == i_value);
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire

[design/uvf_hit_tree.sv]
// Hit reduction: registered OR over groups of cell hit flags.
`default_nettype none
module uvf_hit_tree
    import uvf_pkg::*;
#(
    parameter int N = DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic [N-1:0]                       i_hit,
    output logic [((N + GRP_W - 1) / GRP_W)-1:0]    o_grp
);

    localparam int G = (N + GRP_W - 1) / GRP_W;

    logic [G*GRP_W-1:0] w_pad;
    logic [G-1:0]       r_grp;

    always_comb begin
        w_pad        = '0;
        w_pad[N-1:0] = i_hit;
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < G; g++) begin
            r_grp[g] <= |w_pad[g*GRP_W +: GRP_W];
        end
    end

    assign o_grp = r_grp;

endmodule
`default_nettype wire

[design/unique_value_fifo_top.sv]
// Top level: FIFO of unique signed values built as a row of shifting compare cells.
// Each item steps through S_IDLE, S_CMP, S_RED and S_EXEC; the result strobe is registered.
// One item at a time: busy stays high until the registered compare row and the
// two-level registered OR of the hit flags are through and the queue is updated.
// Reset: synchronous, active low; empties the queue, entry data is not cleared.
// Results are shown for one cycle on o_valid; the receiver cannot stall them.
`default_nettype none
module unique_value_fifo_top
    import uvf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_func,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic                          o_found,
    output logic signed [DATA_W-1:0]      o_popped_value,
    output logic [OCC_W-1:0]              o_occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int G  = (QUEUE_DEPTH + GRP_W - 1) / GRP_W;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [1:0]               r_func;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_valid;
    logic [1:0]               r_status, n_status;
    logic                     r_found, n_found;
    logic signed [DATA_W-1:0] r_popped, n_popped;

    logic signed [DATA_W-1:0] w_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   w_hit;
    logic [G-1:0]             w_grp;
    logic                     w_any;
    logic                     w_push_ok;
    logic                     w_pop_ok;
    logic                     w_full;
    logic [CW+OCC_W-1:0]      w_occ_ext;
    t_cell_ctl                w_ctl [QUEUE_DEPTH];

    assign w_any    = |w_grp;
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));
    assign w_push_ok = (r_state == S_EXEC) && (r_func == OP_PUSH) && !w_any && !w_full;
    assign w_pop_ok  = (r_state == S_EXEC) && (r_func == OP_POP) && (r_count != '0);

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] w_next;

        if (i < QUEUE_DEPTH - 1) begin : g_mid
            assign w_next = w_data[i+1];
        end else begin : g_last
            assign w_next = '0;
        end

        assign w_ctl[i].live  = (CW'(i) < r_count);
        assign w_ctl[i].load  = w_push_ok && (r_count == CW'(i));
        assign w_ctl[i].shift = w_pop_ok;

        uvf_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[i]),
            .i_value     (r_value),
            .i_next_data (w_next),
            .o_data      (w_data[i]),
            .o_hit       (w_hit[i])
        );
    end

    uvf_hit_tree #(
        .N (QUEUE_DEPTH)
    ) u_tree (
        .i_clk (i_clk),
        .i_hit (w_hit),
        .o_grp (w_grp)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = ST_OK;
        n_found  = 1'b0;
        n_popped = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_RED;
            end
            S_RED: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_func)
                    OP_PUSH: begin
                        if (w_any) begin
                            n_status = ST_DUP;
                            n_found  = 1'b1;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_popped = w_data[0];
                            n_count  = r_count - 1'b1;
                        end
                    end
                    OP_SEARCH: begin
                        n_found = w_any;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_popped <= n_popped;
        end
    end

    assign w_occ_ext      = {{OCC_W{1'b0}}, r_count};
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_popped_value = r_popped;
    assign o_occupancy    = w_occ_ext[OCC_W-1:0];

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_valid_after_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_EXEC))
        else $error("result strobe without execute step");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> (r_count == $past(r_count)))
        else $error("occupancy changed outside execute step");

endmodule
`default_nettype wire

[test/tb_top.sv]
// Testbench for unique_value_fifo_top: directed and random items checked against a shadow queue.
`timescale 1ns / 100ps
module tb_top;
    import uvf_pkg::*;

    localparam int  RAND_ITEMS  = 1550;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  REPORT_MAX  = 10;

    typedef struct {
        t_status                  status;
        logic                     found;
        logic signed [DATA_W-1:0] popped;
        logic [OCC_W-1:0]         occ;
    } t_fifo_result;

    class unique_fifo_shadow;
        logic signed [DATA_W-1:0] entries[$];
        t_fifo_result             expected_results[$];
        int                       errors = 0;

        function bit holds(logic signed [DATA_W-1:0] v);
            foreach (entries[k])
                if (entries[k] == v)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_item(t_op op, logic signed [DATA_W-1:0] v);
            t_fifo_result r;
            r.status = ST_OK;
            r.found  = 1'b0;
            r.popped = '0;
            case (op)
                OP_PUSH: begin
                    if (holds(v)) begin
                        r.status = ST_DUP;
                        r.found  = 1'b1;
                    end else if (entries.size() >= DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        entries.push_back(v);
                    end
                end
                OP_POP: begin
                    if (entries.size() == 0)
                        r.status = ST_EMPTY;
                    else
                        r.popped = entries.pop_front();
                end
                OP_SEARCH: r.found = holds(v);
                default: ;
            endcase
            r.occ = OCC_W'(entries.size());
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic found,
                                   logic signed [DATA_W-1:0] popped, logic [OCC_W-1:0] occ);
            t_fifo_result e;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: status %0d found %0d popped %0d occ %0d",
                             status, found, popped, occ);
                return;
            end
            e = expected_results.pop_front();
            if (status !== e.status || found !== e.found || popped !== e.popped
                || occ !== e.occ) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: exp status %0d found %0d popped %0d occ %0d, got status %0d found %0d popped %0d occ %0d",
                             e.status, e.found, e.popped, e.occ, status, found, popped, occ);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start   = 1'b0;
    logic [1:0]               i_func  = OP_NONE;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     busy;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic                     o_found;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [OCC_W-1:0]         o_occupancy;

    unique_fifo_shadow shadow = new();
    int                cycles = 0;

    unique_value_fifo_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_popped_value (o_popped_value),
        .o_occupancy    (o_occupancy)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("unique_value_fifo_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            shadow.check_result(o_status, o_found, o_popped_value, o_occupancy);
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called just after a rising edge; returns just after the edge that ends the gap.
    task automatic send(input t_op op, input logic signed [DATA_W-1:0] v, input int gap);
        start   <= 1'b1;
        i_func  <= op;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        shadow.note_item(op, v);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int                       sent;
        int                       mode;
        int                       len;
        int                       r;
        bit                       quiet;
        bit                       paused;
        t_op                      op;
        logic signed [DATA_W-1:0] v;

        sent   = 0;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_SEARCH, 32'sd5, pick_gap(0));
        send(OP_POP, -32'sd1, pick_gap(0));
        send(OP_PUSH, 32'sh80000000, pick_gap(0));
        send(OP_PUSH, 32'sh7fffffff, pick_gap(0));
        send(OP_PUSH, 32'sd0, pick_gap(0));
        send(OP_PUSH, -32'sd1, pick_gap(0));
        send(OP_PUSH, 32'sh80000000, pick_gap(0));
        send(OP_SEARCH, 32'sh7fffffff, pick_gap(0));
        send(OP_SEARCH, 32'sh7ffffffe, pick_gap(0));
        send(OP_NONE, 32'sh55aa55aa, pick_gap(0));
        for (int k = 0; k < 12; k++)
            send(OP_PUSH, DATA_W'(k * 7919 + 100), pick_gap(0));
        send(OP_PUSH, 32'sd12345, pick_gap(0));
        send(OP_PUSH, 32'sd0, pick_gap(0));
        send(OP_POP, 32'sh0f0f0f0f, pick_gap(0));
        drain();

        while (sent < RAND_ITEMS) begin
            mode  = $urandom_range(0, 3);
            quiet = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(20, 60);
            repeat (len) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: op = (r < 70) ? OP_PUSH : (r < 85) ? OP_POP : (r < 97) ? OP_SEARCH : OP_NONE;
                    1: op = (r < 25) ? OP_PUSH : (r < 80) ? OP_POP : (r < 97) ? OP_SEARCH : OP_NONE;
                    2: op = (r < 40) ? OP_PUSH : (r < 75) ? OP_POP : (r < 97) ? OP_SEARCH : OP_NONE;
                    default: op = (r < 25) ? OP_PUSH : (r < 45) ? OP_POP : (r < 97) ? OP_SEARCH : OP_NONE;
                endcase
                r = $urandom_range(0, 9);
                if (r < 4 && shadow.entries.size() > 0)
                    v = shadow.entries[$urandom_range(0, shadow.entries.size() - 1)];
                else if (r < 7)
                    v = int'($urandom_range(0, 40)) - 20;
                else
                    v = $urandom;
                send(op, v, pick_gap(quiet));
                sent++;
            end
            if (!paused && sent > RAND_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("unique_value_fifo_top test passed");
        else
            $display("unique_value_fifo_top test failed");
        $finish;
    end

endmodule
